/* sv/tes_pkg.sv */
// Shared types and constants for the timed event scheduler.
`timescale 1ns / 1ps
`default_nettype none
package tes_pkg;

	localparam int TABLE_DEPTH_DEF     = 16;
	localparam int IMMEDIATE_DEPTH_DEF = 16;
	localparam int TIME_WIDTH_DEF      = 48;
	localparam int ID_W                = 16;
	localparam int REP_W               = 32;
	localparam int SEQ_W               = 16;

	typedef enum logic [2:0] {
		CMD_TICK, CMD_ADD_IMM, CMD_ADD_TIMED, CMD_RETIME,
		CMD_SET_CYCLE, CMD_SET_REPEAT, CMD_REMOVE, CMD_QUERY
	} cmd_t;

	typedef enum logic [1:0] {KIND_FIRED, KIND_ANSWER, KIND_TICK_DONE} kind_t;

	typedef enum logic [2:0] {
		STAT_OK, STAT_BAD_TIME, STAT_BAD_CYCLE, STAT_UNKNOWN, STAT_FULL
	} status_t;

	typedef enum logic [1:0] {ST_FREE, ST_TIMED, ST_PARKED} ent_st_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MARK, S_MINW, S_IMM, S_PICK, S_FIRE, S_DONE, S_FIND, S_RESP
	} state_t;

	typedef struct packed {
		logic    en;
		logic    mark;
		logic    wr_st;
		ent_st_t st;
		logic    wr_id;
		logic    wr_due;
		logic    wr_cyc;
		logic    wr_rep;
		logic    dec_rep;
		logic    wr_seq;
		logic    clr_fire;
	} cell_op_t;

	typedef struct packed {
		logic push;
		logic shift;
	} fifo_op_t;

endpackage
`default_nettype wire

/* sv/tes_cell.sv */
// One table entry of the event timeline, chained to its neighbors for searches.
`timescale 1ns / 1ps
`default_nettype none
module tes_cell #(
	parameter int TW    = tes_pkg::TIME_WIDTH_DEF,
	parameter int IW    = 4,
	parameter int INDEX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tes_pkg::cell_op_t          op,
	input  logic [IW-1:0]              tgt,
	input  logic [tes_pkg::ID_W-1:0]   d_id,
	input  logic [TW-1:0]              d_due,
	input  logic [TW-1:0]              d_cyc,
	input  logic [tes_pkg::REP_W-1:0]  d_rep,
	input  logic [tes_pkg::SEQ_W-1:0]  d_seq,
	input  logic [TW-1:0]              now,
	input  logic [tes_pkg::ID_W-1:0]   key,
	input  logic                       id_hit_in,
	input  logic                       free_hit_in,
	output tes_pkg::ent_st_t           st,
	output logic [tes_pkg::ID_W-1:0]   id,
	output logic [TW-1:0]              due,
	output logic [TW-1:0]              cyc,
	output logic [tes_pkg::REP_W-1:0]  rep,
	output logic [tes_pkg::SEQ_W-1:0]  seq,
	output logic                       fire,
	output logic                       id_hit_out,
	output logic                       free_hit_out,
	output logic                       id_first,
	output logic                       free_first
);
	import tes_pkg::*;

	ent_st_t          st_q;
	logic [ID_W-1:0]  id_q;
	logic [TW-1:0]    due_q;
	logic [TW-1:0]    cyc_q;
	logic [REP_W-1:0] rep_q;
	logic [SEQ_W-1:0] seq_q;
	logic             fire_q;
	logic             sel;
	logic             id_hit;
	logic             free_hit;

	assign sel      = op.en && (tgt == IW'(INDEX));
	assign id_hit   = (st_q != ST_FREE) && (id_q == key);
	assign free_hit = (st_q == ST_FREE);

	assign id_first     = id_hit && !id_hit_in;
	assign free_first   = free_hit && !free_hit_in;
	assign id_hit_out   = id_hit_in || id_hit;
	assign free_hit_out = free_hit_in || free_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_FREE;
			fire_q <= 1'b0;
		end else begin
			if (sel && op.wr_st) begin
				st_q <= op.st;
			end
			if (op.mark) begin
				fire_q <= (st_q == ST_TIMED) && (due_q == now);
			end else if (sel && op.clr_fire) begin
				fire_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			if (op.wr_id) begin
				id_q <= d_id;
			end
			if (op.wr_due) begin
				due_q <= d_due;
			end
			if (op.wr_cyc) begin
				cyc_q <= d_cyc;
			end
			if (op.wr_rep) begin
				rep_q <= d_rep;
			end else if (op.dec_rep) begin
				rep_q <= rep_q - REP_W'(1);
			end
			if (op.wr_seq) begin
				seq_q <= d_seq;
			end
		end
	end

	assign st   = st_q;
	assign id   = id_q;
	assign due  = due_q;
	assign cyc  = cyc_q;
	assign rep  = rep_q;
	assign seq  = seq_q;
	assign fire = fire_q;

endmodule
`default_nettype wire

/* sv/tes_imm_cell.sv */
// One slot of the immediate event queue; drains toward slot zero.
`timescale 1ns / 1ps
`default_nettype none
module tes_imm_cell #(
	parameter int CW    = 5,
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  tes_pkg::fifo_op_t        op,
	input  logic [CW-1:0]            count,
	input  logic [CW-1:0]            pos,
	input  logic [tes_pkg::ID_W-1:0] push_val,
	input  logic [tes_pkg::ID_W-1:0] next_val,
	input  logic [tes_pkg::ID_W-1:0] key,
	input  logic                     hit_in,
	output logic [tes_pkg::ID_W-1:0] val,
	output logic                     hit_out,
	output logic                     first
);
	import tes_pkg::*;

	logic [ID_W-1:0] val_q;
	logic            hit;

	assign hit     = (CW'(INDEX) < count) && (val_q == key);
	assign first   = hit && !hit_in;
	assign hit_out = hit_in || hit;
	assign val     = val_q;

	always_ff @(posedge clk) begin
		if (op.shift && (CW'(INDEX) >= pos)) begin
			val_q <= next_val;
		end else if (op.push && (CW'(INDEX) == count)) begin
			val_q <= push_val;
		end
	end

endmodule
`default_nettype wire

/* sv/timed_event_scheduler_unit.sv */
// Timed event scheduler top level: command decode, sequencer and cell rows.
//
// Input stream (s_axis): one transfer per command; tuser holds the command
// code, tdata the event id, time value, cycle time and repeat count.
// Output stream (m_axis): result transfers; tuser holds the result kind,
// tlast marks the final result of a command.
// A command is taken only when the previous one has placed its last result
// in the output register. The timeline lives in a row of entry cells that
// search for ids and free slots along a hit chain; the immediate queue is a
// row of cells that shifts toward its head.
// A non-tick command passes a decision step, a walk over all entries for the
// earliest due time and one answer. A tick marks the due entries, walks all
// entries for the earliest due time, emits the queued immediate events one
// at a time while the receiver takes them, then runs an in-order pick walk
// over all entries per due event, a last walk that finds nothing left, and
// the closing result.
// Reset clears the time, id and post counters, empties the queue and frees
// every entry. A stalled receiver holds the sequencer in place; no result is
// dropped.
`timescale 1ns / 1ps
`default_nettype none
module timed_event_scheduler_unit #(
	parameter  int TABLE_DEPTH     = tes_pkg::TABLE_DEPTH_DEF,
	parameter  int IMMEDIATE_DEPTH = tes_pkg::IMMEDIATE_DEPTH_DEF,
	parameter  int TIME_WIDTH      = tes_pkg::TIME_WIDTH_DEF,
	localparam int IDW = ((48 + 2 * TIME_WIDTH + 7) / 8) * 8,
	localparam int ODW = ((20 + TIME_WIDTH + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	// event_id, time_value, cycle_time, repeat_count
	input  logic [IDW-1:0] s_axis_tdata,
	// command
	input  logic [2:0]     s_axis_tuser,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	// result_id, status, is_scheduled, next_event_time
	output logic [ODW-1:0] m_axis_tdata,
	// result_kind
	output logic [1:0]     m_axis_tuser,
	output logic           m_axis_tlast
);
	import tes_pkg::*;

	localparam int TD = TABLE_DEPTH;
	localparam int QD = IMMEDIATE_DEPTH;
	localparam int TW = TIME_WIDTH;
	localparam int IW = $clog2(TD);
	localparam int CW = $clog2(QD + 1);

	localparam logic [TW-1:0] TMAX = {1'b0, {(TW - 1){1'b1}}};
	localparam logic [TW-1:0] TMIN = {1'b1, {(TW - 1){1'b0}}};

	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [TW:0] s;
		s = {a[TW-1], a} + {b[TW-1], b};
		if (s[TW] != s[TW-1]) begin
			return s[TW] ? TMIN : TMAX;
		end
		return s[TW-1:0];
	endfunction

	function automatic logic cycle_bad(input logic [TW-1:0] c);
		return (c == '0) || (c[TW-1] && !(&c));
	endfunction

	// cell rows
	ent_st_t          c_st   [TD];
	logic [ID_W-1:0]  c_id   [TD];
	logic [TW-1:0]    c_due  [TD];
	logic [TW-1:0]    c_cyc  [TD];
	logic [REP_W-1:0] c_rep  [TD];
	logic [SEQ_W-1:0] c_seq  [TD];
	logic             c_fire [TD];
	logic             id_first   [TD];
	logic             free_first [TD];
	logic [TD:0]      id_chain;
	logic [TD:0]      free_chain;
	logic [ID_W-1:0]  q_val   [QD];
	logic             q_first [QD];
	logic [QD:0]      q_chain;

	cell_op_t         cop;
	logic [IW-1:0]    ctgt;
	logic [TW-1:0]    d_due;
	fifo_op_t         fop;
	logic [CW-1:0]    fpos;

	// registers
	state_t           state_q, state_d;
	cmd_t             cmd_q;
	logic [ID_W-1:0]  eid_q;
	logic [TW-1:0]    tv_q, cy_q;
	logic [REP_W-1:0] rp_q;
	logic [TW-1:0]    now_q, now_d;
	logic [SEQ_W-1:0] ps_q, ps_d, ps0_q;
	logic [ID_W-1:0]  nid_q, nid_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [IW-1:0]    idx_q, idx_d;
	logic [TW-1:0]    best_q, best_d, min_q, min_d;
	logic             any_q, any_d;
	logic [IW-1:0]    bidx_q, bidx_d;
	logic [SEQ_W-1:0] bage_q, bage_d;
	logic             bfnd_q, bfnd_d;
	logic [ID_W-1:0]  rid_q, rid_d;
	status_t          rst_q, rst_d;
	logic             rsch_q, rsch_d;
	logic             ov_q;
	kind_t            okind_q;
	logic [ID_W-1:0]  oid_q;
	status_t          ost_q;
	logic             osch_q, olast_q;
	logic [TW-1:0]    onet_q;

	logic             emit;
	kind_t            e_kind;
	logic [ID_W-1:0]  e_id;
	status_t          e_st;
	logic             e_sch, e_last;
	logic             out_free;
	logic             in_xfer;

	logic [IW-1:0]    fidx;
	logic [CW-1:0]    qpos;
	logic             tl_sched;
	logic [TW:0]      tv_sum;
	logic             tv_ovf, tv_lt, tv_park;
	logic             p_timed;
	logic [TW-1:0]    p_due;
	logic [SEQ_W-1:0] age;
	logic             better;
	logic [TW-1:0]    b_sat;

	genvar g;
	generate
		for (g = 0; g < TD; g++) begin : g_cell
			tes_cell #(.TW(TW), .IW(IW), .INDEX(g)) u_cell (
				.clk(clk), .arst_n(arst_n), .op(cop), .tgt(ctgt),
				.d_id(nid_q), .d_due(d_due), .d_cyc(cy_q), .d_rep(rp_q), .d_seq(ps_q),
				.now(now_q), .key(eid_q),
				.id_hit_in(id_chain[g]), .free_hit_in(free_chain[g]),
				.st(c_st[g]), .id(c_id[g]), .due(c_due[g]), .cyc(c_cyc[g]),
				.rep(c_rep[g]), .seq(c_seq[g]), .fire(c_fire[g]),
				.id_hit_out(id_chain[g+1]), .free_hit_out(free_chain[g+1]),
				.id_first(id_first[g]), .free_first(free_first[g])
			);
		end
		for (g = 0; g < QD; g++) begin : g_imm
			logic [ID_W-1:0] nv;
			if (g == QD - 1) begin : g_end
				assign nv = '0;
			end else begin : g_mid
				assign nv = q_val[g+1];
			end
			tes_imm_cell #(.CW(CW), .INDEX(g)) u_imm (
				.clk(clk), .op(fop), .count(cnt_q), .pos(fpos), .push_val(nid_q),
				.next_val(nv), .key(eid_q), .hit_in(q_chain[g]),
				.val(q_val[g]), .hit_out(q_chain[g+1]), .first(q_first[g])
			);
		end
	endgenerate

	assign id_chain[0]   = 1'b0;
	assign free_chain[0] = 1'b0;
	assign q_chain[0]    = 1'b0;

	always_comb begin
		fidx     = '0;
		tl_sched = 1'b0;
		for (int i = 0; i < TD; i++) begin
			if (id_first[i]) begin
				fidx = fidx | IW'(i);
			end
			if ((c_st[i] == ST_TIMED) && (c_id[i] == eid_q)) begin
				tl_sched = 1'b1;
			end
		end
	end

	always_comb begin
		qpos = '0;
		for (int i = 0; i < QD; i++) begin
			if (q_first[i]) begin
				qpos = qpos | CW'(i);
			end
		end
	end

	assign tv_sum  = {now_q[TW-1], now_q} + {tv_q[TW-1], tv_q};
	assign tv_ovf  = !tv_sum[TW] && tv_sum[TW-1];
	assign tv_park = &tv_q;
	assign tv_lt   = tv_q[TW-1] && !tv_park;

	assign p_timed = c_fire[idx_q] ? ((c_rep[idx_q] != '0) && !(&c_cyc[idx_q]))
	                               : (c_st[idx_q] == ST_TIMED);
	assign p_due   = c_fire[idx_q] ? sat_add(now_q, c_cyc[idx_q]) : c_due[idx_q];
	assign age     = ps0_q - c_seq[idx_q];
	assign better  = c_fire[idx_q] && (!bfnd_q || (age > bage_q));
	assign b_sat   = sat_add(now_q, c_cyc[bidx_q]);

	assign out_free      = !ov_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d = state_q;
		now_d   = now_q;
		ps_d    = ps_q;
		nid_d   = nid_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		best_d  = best_q;
		any_d   = any_q;
		min_d   = min_q;
		bidx_d  = bidx_q;
		bage_d  = bage_q;
		bfnd_d  = bfnd_q;
		rid_d   = rid_q;
		rst_d   = rst_q;
		rsch_d  = rsch_q;
		cop     = '0;
		cop.st  = ST_FREE;
		ctgt    = fidx;
		d_due   = tv_sum[TW-1:0];
		fop     = '0;
		fpos    = '0;
		emit    = 1'b0;
		e_kind  = KIND_FIRED;
		e_id    = '0;
		e_st    = STAT_OK;
		e_sch   = 1'b0;
		e_last  = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if (cmd_t'(s_axis_tuser) == CMD_TICK) begin
						now_d   = s_axis_tdata[16 +: TW];
						state_d = S_MARK;
					end else begin
						state_d = S_FIND;
					end
				end
			end
			S_MARK: begin
				cop.mark = 1'b1;
				idx_d    = '0;
				any_d    = 1'b0;
				state_d  = S_MINW;
			end
			S_MINW: begin
				if (p_timed && (!any_q || ($signed(p_due) < $signed(best_q)))) begin
					best_d = p_due;
					any_d  = 1'b1;
				end
				idx_d = idx_q + IW'(1);
				if (idx_q == IW'(TD - 1)) begin
					min_d   = any_d ? best_d : '1;
					state_d = (cmd_q == CMD_TICK) ? S_IMM : S_RESP;
				end
			end
			S_IMM: begin
				if (cnt_q == '0) begin
					idx_d   = '0;
					bfnd_d  = 1'b0;
					state_d = S_PICK;
				end else if (out_free) begin
					emit      = 1'b1;
					e_id      = q_val[0];
					fop.shift = 1'b1;
					cnt_d     = cnt_q - CW'(1);
				end
			end
			S_PICK: begin
				if (better) begin
					bidx_d = idx_q;
					bage_d = age;
					bfnd_d = 1'b1;
				end
				idx_d = idx_q + IW'(1);
				if (idx_q == IW'(TD - 1)) begin
					state_d = bfnd_d ? S_FIRE : S_DONE;
				end
			end
			S_FIRE: begin
				if (out_free) begin
					emit         = 1'b1;
					e_id         = c_id[bidx_q];
					ctgt         = bidx_q;
					d_due        = b_sat;
					cop.en       = 1'b1;
					cop.clr_fire = 1'b1;
					cop.wr_st    = 1'b1;
					if (c_rep[bidx_q] == '0) begin
						cop.st = ST_FREE;
					end else begin
						cop.dec_rep = !c_rep[bidx_q][REP_W-1];
						if (&c_cyc[bidx_q]) begin
							cop.st = ST_PARKED;
						end else begin
							cop.st     = ST_TIMED;
							cop.wr_due = 1'b1;
							cop.wr_seq = 1'b1;
							ps_d       = ps_q + SEQ_W'(1);
						end
					end
					idx_d   = '0;
					bfnd_d  = 1'b0;
					state_d = S_PICK;
				end
			end
			S_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_TICK_DONE;
					e_last  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FIND: begin
				rid_d  = eid_q;
				rst_d  = STAT_OK;
				rsch_d = 1'b0;
				case (cmd_q)
					CMD_ADD_IMM: begin
						if (cnt_q == CW'(QD)) begin
							rid_d = '0;
							rst_d = STAT_FULL;
						end else begin
							fop.push = 1'b1;
							cnt_d    = cnt_q + CW'(1);
							rid_d    = nid_q;
							nid_d    = nid_q + ID_W'(1);
						end
					end
					CMD_ADD_TIMED: begin
						rid_d = '0;
						if (tv_lt || tv_ovf) begin
							rst_d = STAT_BAD_TIME;
						end else if ((rp_q != '0) && cycle_bad(cy_q)) begin
							rst_d = STAT_BAD_CYCLE;
						end else if (!free_chain[TD]) begin
							rst_d = STAT_FULL;
						end else begin
							for (int i = 0; i < TD; i++) begin
								if (free_first[i]) begin
									ctgt = IW'(i);
								end
							end
							cop.en     = 1'b1;
							cop.wr_st  = 1'b1;
							cop.wr_id  = 1'b1;
							cop.wr_cyc = 1'b1;
							cop.wr_rep = 1'b1;
							cop.wr_due = 1'b1;
							cop.wr_seq = 1'b1;
							if (tv_park) begin
								cop.st = ST_PARKED;
							end else begin
								cop.st = ST_TIMED;
								ps_d   = ps_q + SEQ_W'(1);
							end
							rid_d = nid_q;
							nid_d = nid_q + ID_W'(1);
						end
					end
					CMD_RETIME, CMD_SET_CYCLE, CMD_SET_REPEAT: begin
						if (!id_chain[TD]) begin
							rst_d = STAT_UNKNOWN;
						end else if (cmd_q == CMD_RETIME) begin
							if (tv_lt) begin
								cop.en    = 1'b1;
								cop.wr_st = 1'b1;
								cop.st    = ST_FREE;
							end else if (tv_ovf) begin
								rst_d = STAT_BAD_TIME;
							end else if (tv_park) begin
								cop.en    = 1'b1;
								cop.wr_st = 1'b1;
								cop.st    = ST_PARKED;
							end else begin
								cop.en     = 1'b1;
								cop.wr_st  = 1'b1;
								cop.st     = ST_TIMED;
								cop.wr_due = 1'b1;
								cop.wr_seq = 1'b1;
								ps_d       = ps_q + SEQ_W'(1);
							end
						end else if (cmd_q == CMD_SET_CYCLE) begin
							if ((c_rep[fidx] != '0) && cycle_bad(cy_q)) begin
								rst_d = STAT_BAD_CYCLE;
							end else begin
								cop.en     = 1'b1;
								cop.wr_cyc = 1'b1;
							end
						end else begin
							if ((rp_q != '0) && cycle_bad(c_cyc[fidx])) begin
								rst_d = STAT_BAD_CYCLE;
							end else begin
								cop.en     = 1'b1;
								cop.wr_rep = 1'b1;
							end
						end
					end
					CMD_REMOVE: begin
						if (q_chain[QD]) begin
							fop.shift = 1'b1;
							fpos      = qpos;
							cnt_d     = cnt_q - CW'(1);
						end else if (id_chain[TD]) begin
							cop.en    = 1'b1;
							cop.wr_st = 1'b1;
							cop.st    = ST_FREE;
						end else begin
							rst_d = STAT_UNKNOWN;
						end
					end
					default: begin
						rsch_d = q_chain[QD] || tl_sched;
					end
				endcase
				idx_d   = '0;
				any_d   = 1'b0;
				state_d = S_MINW;
			end
			S_RESP: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_ANSWER;
					e_id    = rid_q;
					e_st    = rst_q;
					e_sch   = rsch_q;
					e_last  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			now_q   <= '0;
			ps_q    <= '0;
			nid_q   <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			any_q   <= 1'b0;
			bfnd_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			now_q   <= now_d;
			ps_q    <= ps_d;
			nid_q   <= nid_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			any_q   <= any_d;
			bfnd_q  <= bfnd_d;
			ov_q    <= emit || (ov_q && !m_axis_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q <= cmd_t'(s_axis_tuser);
			eid_q <= s_axis_tdata[15:0];
			tv_q  <= s_axis_tdata[16 +: TW];
			cy_q  <= s_axis_tdata[16 + TW +: TW];
			rp_q  <= s_axis_tdata[16 + 2 * TW +: REP_W];
		end
		if (state_q == S_MARK) begin
			ps0_q <= ps_q;
		end
		best_q <= best_d;
		min_q  <= min_d;
		bidx_q <= bidx_d;
		bage_q <= bage_d;
		rid_q  <= rid_d;
		rst_q  <= rst_d;
		rsch_q <= rsch_d;
		if (emit) begin
			okind_q <= e_kind;
			oid_q   <= e_id;
			ost_q   <= e_st;
			osch_q  <= e_sch;
			olast_q <= e_last;
			onet_q  <= min_q;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tuser  = okind_q;
	assign m_axis_tlast  = olast_q;
	assign m_axis_tdata  = ODW'({onet_q, osch_q, ost_q, oid_q});

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the timed event scheduler unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import tes_pkg::*;

	localparam int TD = 16;
	localparam int QD = 16;
	localparam int TW = 48;
	localparam int IDW = ((48 + 2 * TW + 7) / 8) * 8;
	localparam int ODW = ((20 + TW + 7) / 8) * 8;
	localparam longint TMAX = (64'sd1 <<< (TW - 1)) - 1;
	localparam longint TMIN = -TMAX - 1;
	localparam longint LIMIT = 3000000;

	typedef struct {
		cmd_t       cmd;
		logic [15:0] eid;
		longint     tv;
		longint     cy;
		int         rp;
	} cmd_item_t;

	typedef struct {
		kind_t       kind;
		logic [15:0] id;
		status_t     st;
		logic        sched;
		longint      nxt;
		logic        last;
	} result_t;

	typedef struct {
		ent_st_t     st;
		logic [15:0] id;
		longint      due;
		longint      cyc;
		int          rep;
		logic [15:0] seq;
	} entry_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [IDW-1:0] s_axis_tdata = '0;
	logic [2:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [ODW-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;

	timed_event_scheduler_unit dut (.*);

	always #5 clk = ~clk;

	longint now_t;
	logic [15:0] id_ctr, seq_ctr;
	logic [15:0] imm_q[$];
	entry_t tbl[TD];
	result_t pending_results[$];
	result_t batch[$];
	int errors = 0;
	int send_idle = 0, recv_stall = 0;
	longint cycles = 0;

	task automatic report(string msg);
		$display("mismatch @%0t: %s", $time, msg);
		errors++;
	endtask

	function automatic bit cyc_bad(longint c);
		return c == 0 || c < -1;
	endfunction

	function automatic bit ovf(longint n, longint d);
		if (d < 0 || n < 0) return 0;
		return d > TMAX - n;
	endfunction

	function automatic int find_entry(logic [15:0] id);
		for (int i = 0; i < TD; i++)
			if (tbl[i].st != ST_FREE && tbl[i].id == id) return i;
		return -1;
	endfunction

	function automatic void repost(int i, longint due);
		tbl[i].st = ST_TIMED;
		tbl[i].due = due;
		tbl[i].seq = seq_ctr;
		seq_ctr++;
	endfunction

	function automatic void add_res(kind_t k, logic [15:0] id, status_t s, logic sc);
		result_t r;
		r.kind = k; r.id = id; r.st = s; r.sched = sc; r.nxt = 0; r.last = 0;
		batch.push_back(r);
	endfunction

	function automatic void predict_schedule(cmd_item_t c);
		int s, cnt, t;
		int order[TD];
		logic [15:0] ai, aj;
		longint best;
		bit any;
		status_t st;
		logic sc;
		// the port carries only TW bits of each time field
		c.tv = (c.tv <<< (64 - TW)) >>> (64 - TW);
		c.cy = (c.cy <<< (64 - TW)) >>> (64 - TW);
		batch.delete();
		case (c.cmd)
			CMD_TICK: begin
				now_t = c.tv;
				foreach (imm_q[k]) add_res(KIND_FIRED, imm_q[k], STAT_OK, 0);
				imm_q.delete();
				cnt = 0;
				for (int i = 0; i < TD; i++)
					if (tbl[i].st == ST_TIMED && tbl[i].due == now_t) order[cnt++] = i;
				for (int i = 0; i < cnt; i++)
					for (int j = i + 1; j < cnt; j++) begin
						ai = seq_ctr - tbl[order[i]].seq;
						aj = seq_ctr - tbl[order[j]].seq;
						if (aj > ai || (aj == ai && order[j] < order[i])) begin
							t = order[i]; order[i] = order[j]; order[j] = t;
						end
					end
				for (int i = 0; i < cnt; i++) begin
					s = order[i];
					add_res(KIND_FIRED, tbl[s].id, STAT_OK, 0);
					if (tbl[s].rep == 0) begin
						tbl[s].st = ST_FREE;
						continue;
					end
					if (tbl[s].rep > 0) tbl[s].rep--;
					if (tbl[s].cyc == -1) tbl[s].st = ST_PARKED;
					else if (tbl[s].cyc > 0 && now_t > TMAX - tbl[s].cyc) repost(s, TMAX);
					else if (tbl[s].cyc < 0 && now_t < TMIN - tbl[s].cyc) repost(s, TMIN);
					else repost(s, now_t + tbl[s].cyc);
				end
				add_res(KIND_TICK_DONE, 0, STAT_OK, 0);
			end
			CMD_ADD_IMM: begin
				if (imm_q.size() >= QD) add_res(KIND_ANSWER, 0, STAT_FULL, 0);
				else begin
					imm_q.push_back(id_ctr);
					add_res(KIND_ANSWER, id_ctr, STAT_OK, 0);
					id_ctr++;
				end
			end
			CMD_ADD_TIMED: begin
				s = -1;
				for (int i = TD - 1; i >= 0; i--) if (tbl[i].st == ST_FREE) s = i;
				if (c.tv < -1 || ovf(now_t, c.tv)) add_res(KIND_ANSWER, 0, STAT_BAD_TIME, 0);
				else if (c.rp != 0 && cyc_bad(c.cy))
					add_res(KIND_ANSWER, 0, STAT_BAD_CYCLE, 0);
				else if (s < 0) add_res(KIND_ANSWER, 0, STAT_FULL, 0);
				else begin
					tbl[s].id = id_ctr; tbl[s].cyc = c.cy; tbl[s].rep = c.rp;
					tbl[s].due = 0; tbl[s].seq = 0;
					if (c.tv == -1) tbl[s].st = ST_PARKED;
					else repost(s, now_t + c.tv);
					add_res(KIND_ANSWER, id_ctr, STAT_OK, 0);
					id_ctr++;
				end
			end
			CMD_RETIME, CMD_SET_CYCLE, CMD_SET_REPEAT: begin
				st = STAT_OK;
				s = find_entry(c.eid);
				if (s < 0) st = STAT_UNKNOWN;
				else if (c.cmd == CMD_RETIME) begin
					if (c.tv < -1) tbl[s].st = ST_FREE;
					else if (ovf(now_t, c.tv)) st = STAT_BAD_TIME;
					else if (c.tv == -1) tbl[s].st = ST_PARKED;
					else repost(s, now_t + c.tv);
				end else if (c.cmd == CMD_SET_CYCLE) begin
					if (tbl[s].rep != 0 && cyc_bad(c.cy)) st = STAT_BAD_CYCLE;
					else tbl[s].cyc = c.cy;
				end else begin
					if (c.rp != 0 && cyc_bad(tbl[s].cyc)) st = STAT_BAD_CYCLE;
					else tbl[s].rep = c.rp;
				end
				add_res(KIND_ANSWER, c.eid, st, 0);
			end
			CMD_REMOVE: begin
				st = STAT_UNKNOWN;
				foreach (imm_q[k])
					if (imm_q[k] == c.eid) begin
						imm_q.delete(k);
						st = STAT_OK;
						break;
					end
				if (st != STAT_OK) begin
					s = find_entry(c.eid);
					if (s >= 0) begin
						tbl[s].st = ST_FREE;
						st = STAT_OK;
					end
				end
				add_res(KIND_ANSWER, c.eid, st, 0);
			end
			default: begin
				sc = 0;
				foreach (imm_q[k]) if (imm_q[k] == c.eid) sc = 1;
				for (int i = 0; i < TD; i++)
					if (tbl[i].st == ST_TIMED && tbl[i].id == c.eid) sc = 1;
				add_res(KIND_ANSWER, c.eid, STAT_OK, sc);
			end
		endcase
		any = 0; best = -1;
		for (int i = 0; i < TD; i++)
			if (tbl[i].st == ST_TIMED && (!any || tbl[i].due < best)) begin
				best = tbl[i].due;
				any = 1;
			end
		foreach (batch[i]) begin
			batch[i].nxt = best;
			batch[i].last = (i == batch.size() - 1);
			pending_results.push_back(batch[i]);
		end
	endfunction

	task automatic send_cmd(cmd_item_t c);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= c.cmd;
		s_axis_tdata <= {c.rp, c.cy[TW-1:0], c.tv[TW-1:0], c.eid};
		do @(posedge clk); while (!s_axis_tready);
		predict_schedule(c);
		@(negedge clk);
	endtask

	// output side: random stall at falling edge, check at rising edge
	always @(negedge clk) m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);

	always @(posedge clk) begin
		result_t e;
		logic [TW-1:0] gnxt;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) report("result with nothing expected");
			else begin
				e = pending_results.pop_front();
				gnxt = m_axis_tdata[20 +: TW];
				if (m_axis_tuser != e.kind)
					report($sformatf("kind %0d exp %0d", m_axis_tuser, e.kind));
				if (m_axis_tdata[15:0] != e.id)
					report($sformatf("id %0h exp %0h", m_axis_tdata[15:0], e.id));
				if (m_axis_tdata[18:16] != e.st)
					report($sformatf("status %0d exp %0d", m_axis_tdata[18:16], e.st));
				if (m_axis_tdata[19] != e.sched)
					report($sformatf("is_scheduled %0b exp %0b", m_axis_tdata[19], e.sched));
				if (gnxt != e.nxt[TW-1:0])
					report($sformatf("next time %0h exp %0h", gnxt, e.nxt[TW-1:0]));
				if (m_axis_tlast != e.last)
					report($sformatf("last %0b exp %0b", m_axis_tlast, e.last));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic cmd_item_t mk(cmd_t c, logic [15:0] id, longint tv, longint cy, int rp);
		cmd_item_t r;
		r.cmd = c; r.eid = id; r.tv = tv; r.cy = cy; r.rp = rp;
		return r;
	endfunction

	function automatic longint rnd_wide();
		longint v;
		v = {$urandom, $urandom};
		v = v <<< 16;
		return v >>> 16;
	endfunction

	function automatic cmd_item_t rnd_cmd();
		cmd_item_t c;
		int p;
		p = $urandom_range(99);
		c.eid = ($urandom_range(9) == 0) ? 16'($urandom) : id_ctr - 16'($urandom_range(1, 20));
		c.cy = $urandom_range(1, 6);
		c.rp = $urandom_range(3) - 1;
		c.tv = $urandom_range(0, 6);
		if (p < 30) begin
			c.cmd = CMD_TICK;
			c.tv = now_t + $urandom_range(0, 3);
		end else if (p < 40) c.cmd = CMD_ADD_IMM;
		else if (p < 65) c.cmd = CMD_ADD_TIMED;
		else c.cmd = cmd_t'($urandom_range(3, 7));
		if ($urandom_range(9) == 0) c.tv = ($urandom_range(1)) ? -1 : rnd_wide();
		if ($urandom_range(9) == 0) c.cy = $urandom_range(1) ? -1 : rnd_wide();
		if ($urandom_range(14) == 0) c.cy = 0;
		if ($urandom_range(9) == 0) c.rp = $urandom;
		return c;
	endfunction

	task automatic drain_results();
		s_axis_tvalid <= 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	cmd_item_t directed[$];
	cmd_item_t c;

	initial begin
		now_t = 0; id_ctr = 0; seq_ctr = 0;
		for (int i = 0; i < TD; i++) tbl[i].st = ST_FREE;
		repeat (12) @(negedge clk);
		arst_n = 1;
		directed = '{
			mk(CMD_TICK, 0, 0, 0, 0),
			mk(CMD_QUERY, 16'hFFFF, 0, 0, 0),
			mk(CMD_REMOVE, 16'h1234, 0, 0, 0),
			mk(CMD_RETIME, 16'h0, 5, 0, 0),
			mk(CMD_ADD_TIMED, 0, -2, 1, 0),
			mk(CMD_ADD_TIMED, 0, TMAX, 1, 0),
			mk(CMD_ADD_TIMED, 0, 3, 0, 2),
			mk(CMD_ADD_TIMED, 0, 3, -5, 1),
			mk(CMD_ADD_IMM, 0, 0, 0, 0),
			mk(CMD_ADD_TIMED, 0, 2, 1, -1),
			mk(CMD_ADD_TIMED, 0, 2, -1, 1),
			mk(CMD_ADD_TIMED, 0, -1, TMAX, 2147483647),
			mk(CMD_ADD_TIMED, 0, 2, TMAX, 0),
			mk(CMD_QUERY, 0, 0, 0, 0),
			mk(CMD_SET_CYCLE, 1, 0, 0, 0),
			mk(CMD_SET_REPEAT, 4, 0, 0, 0),
			mk(CMD_SET_REPEAT, 2, 0, 0, 3),
			mk(CMD_TICK, 0, 2, 0, 0),
			mk(CMD_TICK, 0, 3, 0, 0),
			mk(CMD_RETIME, 3, TMAX, 0, 0),
			mk(CMD_RETIME, 3, -1, 0, 0),
			mk(CMD_RETIME, 1, -7, 0, 0),
			mk(CMD_TICK, 0, TMAX - 1, 0, 0),
			mk(CMD_ADD_TIMED, 0, 1, 5, 1),
			mk(CMD_TICK, 0, TMAX, 0, 0)
		};
		foreach (directed[i]) send_cmd(directed[i]);
		// fill both stores
		for (int i = 0; i < 17; i++) send_cmd(mk(CMD_ADD_IMM, 0, 0, 0, 0));
		for (int i = 0; i < 17; i++) send_cmd(mk(CMD_ADD_TIMED, 0, -1, 1, 0));
		send_cmd(mk(CMD_TICK, 0, TMIN, 0, 0));
		for (int i = 0; i < 16; i++) send_cmd(mk(CMD_REMOVE, id_ctr - 16'(i + 1), 0, 0, 0));
		send_cmd(mk(CMD_TICK, 0, 0, 0, 0));
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 80 : 13) : 0;
			recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 80 : 13) : 0;
			for (int i = 0; i < 7; i++) begin
				c = rnd_cmd();
				send_cmd(c);
			end
			drain_results();
		end
		send_idle = 0; recv_stall = 0;
		drain_results();
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire

/* timed_event_scheduler_unit.f */
sv/tes_pkg.sv
sv/tes_cell.sv
sv/tes_imm_cell.sv
sv/timed_event_scheduler_unit.sv
tb/sv/testbench.sv
